[hdl/whb_pkg.sv]
`default_nettype none

package whb_pkg;

   // fixed field widths
   localparam int OPCODE_W         = 2;
   localparam int CHAN_W           = 4;
   localparam int AGE_W            = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;

   localparam int CHANNELS_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd10;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FEED  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK   = 2'd1;

   // result kinds
   localparam logic KIND_QUERY   = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_FEED  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic              in_range;
      logic [CHAN_W-1:0] channel;
   } cmd_type;

   typedef struct packed {
      logic [AGE_W-1:0] timeout;
      logic             check_en;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] channel_id;
      logic              registered;
      logic              alive;
      logic [AGE_W-1:0]  age;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/whb_front.sv]
`default_nettype none

module whb_front #(
   parameter int CHANNELS = whb_pkg::CHANNELS_DEFAULT
) (
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [whb_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire  [whb_pkg::CHAN_W-1:0]       req_channel,
   input  wire                              queue_full,
   output logic                             push,
   output whb_pkg::cmd_type                 cmd
);

   // wide enough to hold CHANNELS up to 64
   localparam int CMP_W = 7;

   logic in_range;
   logic keep;

   assign in_range  = {{(CMP_W-whb_pkg::CHAN_W){1'b0}}, req_channel} < CMP_W'(CHANNELS);
   assign req_stall = queue_full;

   always_comb begin
      cmd.channel  = req_channel;
      cmd.in_range = in_range;
      cmd.kind     = whb_pkg::CMD_TICK;
      keep         = 1'b0;
      unique case (req_opcode)
         whb_pkg::OP_TICK: begin
            keep = 1'b1;
         end
         whb_pkg::OP_FEED: begin
            // feeds beyond the table are dropped here
            cmd.kind = whb_pkg::CMD_FEED;
            keep     = in_range;
         end
         whb_pkg::OP_QUERY: begin
            cmd.kind = whb_pkg::CMD_QUERY;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !queue_full && keep;

endmodule

`default_nettype wire

[hdl/whb_queue.sv]
`default_nettype none

module whb_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  whb_pkg::cmd_type push_data,
   input  wire              pop,
   output logic             full,
   output logic             not_empty,
   output whb_pkg::cmd_type head
);

   localparam int PTR_W = (whb_pkg::QUEUE_DEPTH > 1) ? $clog2(whb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(whb_pkg::QUEUE_DEPTH + 1);

   whb_pkg::cmd_type slot_ff [whb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(whb_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(whb_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/whb_engine.sv]
`default_nettype none

module whb_engine #(
   parameter int CHANNELS = whb_pkg::CHANNELS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  whb_pkg::cfg_type              cfg,
   input  wire                           cmd_valid,
   input  whb_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output whb_pkg::rsp_type              rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int AGE_W = whb_pkg::AGE_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_QREPLY = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CHANNELS-1:0] reg_flags_ff, reg_flags_in;
   logic [CHANNELS-1:0] alive_flags_ff, alive_flags_in;

   // age store: one write port, one registered read port
   logic [AGE_W-1:0] age_mem [CHANNELS];
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [AGE_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [AGE_W-1:0] rd_data_ff;

   // query context
   logic                       q_in_range_ff, q_in_range_in;
   logic [whb_pkg::CHAN_W-1:0] q_chan_ff, q_chan_in;
   logic [IDX_W-1:0]           q_idx_ff, q_idx_in;

   // scan pipeline: read stage and update stage
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;

   // one timeout report held back until it is known whether it is the final one
   logic             held_valid_ff, held_valid_in;
   logic [IDX_W-1:0] held_idx_ff, held_idx_in;
   logic [AGE_W-1:0] held_age_ff, held_age_in;

   logic             rsp_valid_ff;
   whb_pkg::rsp_type rsp_data_ff;
   logic             push;
   whb_pkg::rsp_type push_data;
   logic             out_free;

   logic [IDX_W-1:0] cmd_idx;
   logic             issue;
   logic [AGE_W-1:0] new_age;
   logic             hit;
   logic             stall;

   assign cmd_idx  = IDX_W'(cmd.channel);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = (scan_ff < CNT_W'(CHANNELS));
   assign new_age  = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
   assign hit      = cfg.check_en && alive_flags_ff[proc_idx_ff] && (new_age > cfg.timeout);

   always_comb begin
      state_in       = state_ff;
      reg_flags_in   = reg_flags_ff;
      alive_flags_in = alive_flags_ff;
      q_in_range_in  = q_in_range_ff;
      q_chan_in      = q_chan_ff;
      q_idx_in       = q_idx_ff;
      scan_in        = scan_ff;
      proc_valid_in  = proc_valid_ff;
      proc_idx_in    = proc_idx_ff;
      held_valid_in  = held_valid_ff;
      held_idx_in    = held_idx_ff;
      held_age_in    = held_age_ff;
      cmd_pop        = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = proc_idx_ff;
      wr_data        = new_age;
      rd_en          = 1'b0;
      rd_addr        = scan_ff[IDX_W-1:0];
      push           = 1'b0;
      stall          = 1'b0;

      push_data.kind       = whb_pkg::KIND_TIMEOUT;
      push_data.channel_id = whb_pkg::CHAN_W'(held_idx_ff);
      push_data.registered = 1'b1;
      push_data.alive      = 1'b0;
      push_data.age        = held_age_ff;
      push_data.last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  whb_pkg::CMD_FEED: begin
                     reg_flags_in[cmd_idx]   = 1'b1;
                     alive_flags_in[cmd_idx] = 1'b1;
                     wr_en   = 1'b1;
                     wr_addr = cmd_idx;
                     wr_data = '0;
                  end
                  whb_pkg::CMD_QUERY: begin
                     rd_en         = cmd.in_range;
                     rd_addr       = cmd_idx;
                     q_in_range_in = cmd.in_range;
                     q_chan_in     = cmd.channel;
                     q_idx_in      = cmd_idx;
                     state_in      = ST_QREPLY;
                  end
                  default: begin
                     scan_in       = '0;
                     proc_valid_in = 1'b0;
                     held_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
               endcase
            end
         end
         ST_QREPLY: begin
            push_data.kind       = whb_pkg::KIND_QUERY;
            push_data.channel_id = q_chan_ff;
            push_data.registered = q_in_range_ff && reg_flags_ff[q_idx_ff];
            push_data.alive      = q_in_range_ff && reg_flags_ff[q_idx_ff]
                                   && alive_flags_ff[q_idx_ff];
            push_data.age        = push_data.registered ? rd_data_ff : '0;
            push_data.last       = 1'b1;
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (proc_valid_ff && reg_flags_ff[proc_idx_ff]) begin
               if (hit && held_valid_ff && !out_free) begin
                  stall = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  if (hit) begin
                     alive_flags_in[proc_idx_ff] = 1'b0;
                     push          = held_valid_ff;
                     held_valid_in = 1'b1;
                     held_idx_in   = proc_idx_ff;
                     held_age_in   = new_age;
                  end
               end
            end
            if (!stall) begin
               proc_valid_in = issue;
               proc_idx_in   = scan_ff[IDX_W-1:0];
               if (issue) begin
                  rd_en   = 1'b1;
                  scan_in = scan_ff + 1'b1;
               end
               if (!proc_valid_ff && !issue) begin
                  if (held_valid_ff) begin
                     push_data.last = 1'b1;
                     if (out_free) begin
                        push          = 1'b1;
                        held_valid_in = 1'b0;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         reg_flags_ff   <= '0;
         alive_flags_ff <= '0;
         proc_valid_ff  <= 1'b0;
         held_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         reg_flags_ff   <= reg_flags_in;
         alive_flags_ff <= alive_flags_in;
         proc_valid_ff  <= proc_valid_in;
         held_valid_ff  <= held_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_in_range_ff <= q_in_range_in;
      q_chan_ff     <= q_chan_in;
      q_idx_ff      <= q_idx_in;
      scan_ff       <= scan_in;
      proc_idx_ff   <= proc_idx_in;
      held_idx_ff   <= held_idx_in;
      held_age_ff   <= held_age_in;
      if (push) begin
         rsp_data_ff <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         age_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= age_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_alive_needs_reg: assert property (@(posedge clock) disable iff (reset)
      (alive_flags_ff & ~reg_flags_ff) == '0)
      else $error("alive flag set on unregistered channel");

   a_timeout_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.kind == whb_pkg::KIND_TIMEOUT)
      |-> rsp_data_ff.registered && !rsp_data_ff.alive)
      else $error("timeout report with bad status bits");

   a_feed_registers: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && (cmd.kind == whb_pkg::CMD_FEED)
      |=> reg_flags_ff[$past(cmd_idx)] && alive_flags_ff[$past(cmd_idx)])
      else $error("feed did not register channel");

   a_held_in_scan: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (state_ff == ST_SCAN))
      else $error("timeout report left over after scan");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[hdl/multi_channel_heartbeat_watchdog.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_opcode, req_channel
// rsp      out        rsp_valid / rsp_stall  rsp_report_kind, rsp_channel_id, rsp_registered,
//                                            rsp_alive_flag, rsp_age_ticks, rsp_last
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Feed: handled in the back end's idle state. Query: registered read of the age store,
// then a reply state. Tick: the pop, one issue per channel through the single age store
// port, the update of the last channel and a closing step, plus any stalls on the rsp
// side while a timeout report waits to go out.
// Synchronous active-high reset clears all flags; the age store needs no clearing pass
// since an age is only used for a registered channel.
// A two-entry queue parts the front from the back; rsp has its own output register.
`default_nettype none

module multi_channel_heartbeat_watchdog #(
   parameter int CHANNELS = whb_pkg::CHANNELS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [whb_pkg::OPCODE_W-1:0]       req_opcode,
   input  wire  [whb_pkg::CHAN_W-1:0]         req_channel,

   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_report_kind,
   output logic [whb_pkg::CHAN_W-1:0]         rsp_channel_id,
   output logic                               rsp_registered,
   output logic                               rsp_alive_flag,
   output logic [whb_pkg::AGE_W-1:0]          rsp_age_ticks,
   output logic                               rsp_last,

   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [whb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [whb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // config registers
   logic [whb_pkg::AGE_W-1:0] timeout_ff;
   logic                      check_en_ff;
   whb_pkg::cfg_type          cfg;

   // front to queue
   logic             front_push;
   whb_pkg::cmd_type front_cmd;
   logic             queue_full;

   // queue to back
   logic             queue_not_empty;
   whb_pkg::cmd_type queue_head;
   logic             queue_pop;

   whb_pkg::rsp_type rsp_data;

   // the user must make writes only while idle; the block does not enforce it, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= whb_pkg::TIMEOUT_RESET;
         check_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            whb_pkg::CSR_TIMEOUT: timeout_ff  <= csr_wdata[whb_pkg::AGE_W-1:0];
            whb_pkg::CSR_CHECK:   check_en_ff <= csr_wdata[0];
            default: ; // unknown index: no effect
         endcase
      end
   end

   assign cfg.timeout  = timeout_ff;
   assign cfg.check_en = check_en_ff;

   whb_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_channel (req_channel),
      .queue_full  (queue_full),
      .push        (front_push),
      .cmd         (front_cmd)
   );

   whb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   whb_engine #(
      .CHANNELS (CHANNELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_head),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_report_kind = rsp_data.kind;
   assign rsp_channel_id  = rsp_data.channel_id;
   assign rsp_registered  = rsp_data.registered;
   assign rsp_alive_flag  = rsp_data.alive;
   assign rsp_age_ticks   = rsp_data.age;
   assign rsp_last        = rsp_data.last;

endmodule

`default_nettype wire
